// File: rtl/nsfp_pkg.sv
// ----------------------------------------------------------------------------
// nsfp_pkg: shared types and constants of the netstring frame parser
// Result record, result kinds, error codes and default parameter values.
// ----------------------------------------------------------------------------
package nsfp_pkg;

  // Default parameter values for the top level.
  localparam int unsigned MAX_LENGTH_CHARS = 39;
  localparam int unsigned LENGTH_BITS      = 32;

  // Fixed field widths of the stream and configuration interfaces.
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned FRAME_LEN_W = 32;
  localparam int unsigned CFG_W       = 32;

  localparam logic [CFG_W-1:0] MAX_LENGTH_RESET = 32'd65535;

  // Register map, indexed by word address.
  typedef enum logic [0:0] {
    REG_MAX_LENGTH = 1'b0
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_START  = 3'd1,
    ERR_NO_LENGTH = 3'd2,
    ERR_TOO_LONG  = 3'd3,
    ERR_NO_COMMA  = 3'd4,
    ERR_EARLY_END = 3'd5
  } err_e;

  typedef struct packed {
    kind_e                  kind;
    logic [DATA_W-1:0]      payload_byte;
    logic [FRAME_LEN_W-1:0] frame_length;
    err_e                   error_code;
  } result_t;

  // Occupancy of the output stage as seen by the parser.
  typedef struct packed {
    logic room;        // a new beat can be taken this cycle
    logic skid_valid;  // the skid entry holds a result
  } stage_status_t;

endpackage

// File: rtl/nsfp_out_stage.sv
// ----------------------------------------------------------------------------
// nsfp_out_stage: two-entry output stage of the netstring frame parser
// An output register plus a skid entry, so the parser can take one more beat
// after the consumer stalls.
// ----------------------------------------------------------------------------
module nsfp_out_stage
  import nsfp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  result_t       push_data_i,
  output stage_status_t status_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output result_t       out_data_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q, out_data_d;
  result_t skid_data_q, skid_data_d;
  logic    pop;

  assign pop = out_valid_q && out_ready_i;

  // The parser only pushes while the skid entry is empty.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_data_d  = push_data_i;
      end
    end else if (!out_valid_q) begin
      out_valid_d = push_i;
      out_data_d  = push_data_i;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign status_o.room       = !skid_valid_q;
  assign status_o.skid_valid = skid_valid_q;
  assign out_valid_o         = out_valid_q;
  assign out_data_o          = out_data_q;

endmodule

// File: rtl/netstring_frame_parser_core.sv
// ----------------------------------------------------------------------------
// netstring_frame_parser_core: byte-serial netstring frame parser
// Parses frames of the form '&' <decimal length> ':' <payload> ',' one byte
// per beat. Every payload byte comes out as a result beat, the closing comma
// gives a completion beat carrying the length, and a malformed frame gives an
// error beat and returns the parser to idle. Length digits, trailing length
// characters, the colon and the opening ampersand produce no result, and
// neither does end of stream while idle. The parser takes one input beat per
// clock cycle for as long as the consumer keeps up; each result is registered
// in the output stage. The rate rests on the single registered step between
// the input port and the output register: the state update (a multiply by
// ten done with shifts and two adds, then a compare with max_length) is
// combinational. A two-entry output stage lets the parser take one more beat
// after the consumer stalls; in_ready_o drops only when both entries are full.
// The length register max_length (word 0 of the APB-style port, reset 65535)
// may be written only while the parser is idle. There is no clearing pass
// after reset: the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module netstring_frame_parser_core
  import nsfp_pkg::*;
#(
  parameter int unsigned MaxLengthChars = MAX_LENGTH_CHARS,  // 1 to 63
  parameter int unsigned LengthBits     = LENGTH_BITS        // 8 to 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  // Input stream.
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [DATA_W-1:0]      data_byte_i,
  input  logic                   end_of_stream_i,

  // Result stream.
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output kind_e                  kind_o,
  output logic [DATA_W-1:0]      payload_byte_o,
  output logic [FRAME_LEN_W-1:0] frame_length_o,
  output err_e                   error_code_o,

  // Configuration port.
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [CFG_W-1:0]       pwdata,
  output logic [CFG_W-1:0]       prdata,
  output logic                   pready
);

  localparam int unsigned CntW  = $clog2(MaxLengthChars + 1);
  localparam int unsigned ProdW = LengthBits + 4;
  localparam int unsigned ExtW  = (LengthBits > CFG_W) ? LengthBits : CFG_W;

  localparam logic [DATA_W-1:0] CHAR_AMP   = 8'h26;  // '&'
  localparam logic [DATA_W-1:0] CHAR_COLON = 8'h3A;  // ':'
  localparam logic [DATA_W-1:0] CHAR_COMMA = 8'h2C;  // ','
  localparam logic [DATA_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [DATA_W-1:0] CHAR_NINE  = 8'h39;  // '9'

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_PAY   = 4'b0100,
    PH_COMMA = 4'b1000
  } phase_e;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] max_length_q;
  logic             cfg_write;

  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MAX_LENGTH);
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_MAX_LENGTH) ? max_length_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MAX_LENGTH_RESET;
    end else if (cfg_write) begin
      max_length_q <= pwdata;
    end
  end

  // --------------------------------------------------------------------------
  // Parser state
  // --------------------------------------------------------------------------
  phase_e                phase_q, phase_d;
  logic [CntW-1:0]       cnt_q, cnt_d, cnt_inc;
  logic [LengthBits-1:0] len_q, len_d;
  logic [LengthBits-1:0] rem_q, rem_d;
  logic                  ended_q, ended_d;
  logic                  over_q, over_d;

  stage_status_t         stage_status;
  logic                  in_fire;
  logic                  is_digit;
  logic [3:0]            digit_val;
  logic [ProdW-1:0]      len_times_ten;
  logic                  digit_overflow;
  logic [ExtW-1:0]       max_ext;
  logic                  do_finish;
  logic                  err_hit;
  err_e                  err_code;
  logic                  res_valid;
  result_t               res;
  result_t               out_data;

  assign in_ready_o = stage_status.room;
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_digit  = (data_byte_i >= CHAR_ZERO) && (data_byte_i <= CHAR_NINE);
  assign digit_val = 4'(data_byte_i - CHAR_ZERO);
  assign cnt_inc   = cnt_q + 1'b1;

  // Multiply by ten as (x << 3) + (x << 1), then add the new digit. Any bit
  // above the length width means the decimal value no longer fits.
  assign len_times_ten = (ProdW'(len_q) << 3) + (ProdW'(len_q) << 1) + ProdW'(digit_val);
  assign digit_overflow = |len_times_ten[ProdW-1:LengthBits];

  assign max_ext = ExtW'(max_length_q);

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    rem_d     = rem_q;
    ended_d   = ended_q;
    over_d    = over_q;
    do_finish = 1'b0;
    err_hit   = 1'b0;
    err_code  = ERR_NONE;
    res_valid = 1'b0;
    res       = '{kind: KIND_BYTE, payload_byte: '0, frame_length: '0, error_code: ERR_NONE};

    if (in_fire) begin
      if (end_of_stream_i) begin
        // End of stream is harmless between frames and an error inside one.
        if (phase_q != PH_IDLE) begin
          err_hit  = 1'b1;
          err_code = ERR_EARLY_END;
        end
      end else begin
        unique case (phase_q)
          PH_LEN: begin
            if (data_byte_i == CHAR_COLON) begin
              if (cnt_q == '0) begin
                err_hit  = 1'b1;
                err_code = ERR_NO_LENGTH;
              end else begin
                do_finish = 1'b1;
              end
            end else if ((cnt_q == '0) && !is_digit) begin
              err_hit  = 1'b1;
              err_code = ERR_NO_LENGTH;
            end else begin
              if (!is_digit) begin
                ended_d = 1'b1;
              end else if (!ended_q) begin
                if (over_q || digit_overflow) begin
                  len_d  = '1;
                  over_d = 1'b1;
                end else begin
                  len_d = len_times_ten[LengthBits-1:0];
                end
              end
              cnt_d = cnt_inc;
              // Too many length characters without a colon: the field closes here and is
              // checked like any other, so the payload (or, for a zero length, the comma) or an error follows.
              if (cnt_inc >= CntW'(MaxLengthChars)) begin
                do_finish = 1'b1;
              end
            end
          end
          PH_PAY: begin
            res_valid        = 1'b1;
            res.kind         = KIND_BYTE;
            res.payload_byte = data_byte_i;
            rem_d            = rem_q - 1'b1;
            if (rem_d == '0) begin
              phase_d = PH_COMMA;
            end
          end
          PH_COMMA: begin
            if (data_byte_i != CHAR_COMMA) begin
              err_hit  = 1'b1;
              err_code = ERR_NO_COMMA;
            end else begin
              phase_d          = PH_IDLE;
              res_valid        = 1'b1;
              res.kind         = KIND_DONE;
              res.frame_length = FRAME_LEN_W'(ExtW'(len_q));
            end
          end
          default: begin
            // Idle: only the start marker opens a frame.
            if (data_byte_i != CHAR_AMP) begin
              err_hit  = 1'b1;
              err_code = ERR_NO_START;
            end else begin
              phase_d = PH_LEN;
              cnt_d   = '0;
              len_d   = '0;
              ended_d = 1'b0;
              rem_d   = '0;
              over_d  = 1'b0;
            end
          end
        endcase
      end

      // The length field is complete: reject it, or enter the payload (or the comma phase for a zero length).
      if (do_finish) begin
        if (over_d || (ExtW'(len_d) > max_ext)) begin
          err_hit  = 1'b1;
          err_code = ERR_TOO_LONG;
        end else begin
          rem_d   = len_d;
          phase_d = (len_d == '0) ? PH_COMMA : PH_PAY;
        end
      end

      if (err_hit) begin
        phase_d        = PH_IDLE;
        res_valid      = 1'b1;
        res.kind       = KIND_ERR;
        res.error_code = err_code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      len_q   <= '0;
      rem_q   <= '0;
      ended_q <= 1'b0;
      over_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      ended_q <= ended_d;
      over_q  <= over_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage
  // --------------------------------------------------------------------------
  nsfp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .status_o    (stage_status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign kind_o         = out_data.kind;
  assign payload_byte_o = out_data.payload_byte;
  assign frame_length_o = out_data.frame_length;
  assign error_code_o   = out_data.error_code;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // While in the payload phase at least one payload byte is still owed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAY) |-> (rem_q != '0))
    else $error("payload phase with no bytes remaining");

  // Any error beat sends the parser back to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res_valid && (res.kind == KIND_ERR)) |=> (phase_q == PH_IDLE))
    else $error("parser not idle after an error");

  // The skid entry is only ever filled behind a waiting output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_status.skid_valid |-> out_valid_o)
    else $error("skid entry holds a result while the output is empty");

  // A payload beat carries no length and no error code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_BYTE)) |->
      ((frame_length_o == '0) && (error_code_o == ERR_NONE)))
    else $error("payload beat with length or error code set");

endmodule
